// ===== rtl/core/bch_31_21_parity_corrector_top_macros.svh =====
// Assertion macros for the BCH(31,21) corrector.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BCH_31_21_PARITY_CORRECTOR_TOP_MACROS_SVH
`define BCH_31_21_PARITY_CORRECTOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define BCH_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("BCH corrector assertion failed");

`define BCH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("BCH corrector assertion failed");

`define BCH_ASSERT_DELAY3(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##3 (cons)) \
        else $error("BCH corrector assertion failed");

`else

`define BCH_ASSERT(label, prop)

`define BCH_ASSERT_NEXT(label, ante, cons)

`define BCH_ASSERT_DELAY3(label, ante, cons)

`endif

`endif

// ===== rtl/core/bch_pkg.sv =====
package bch_pkg;

    localparam int CodeBits = 31;
    localparam int SynBits  = 10;
    localparam int WordBits = 32;
    localparam logic [SynBits:0] GenPoly = 11'h769;

    typedef logic [WordBits-1:0]              word_t;
    typedef logic [SynBits-1:0]               syn_t;
    typedef logic [CodeBits-1:0]              flip_t;
    typedef logic [CodeBits-1:0][SynBits-1:0] cols_t;
    typedef logic [SynBits-1:0][CodeBits-1:0] masks_t;

    // Syndrome of a single error at code position i is x^i mod g(x).
    function automatic cols_t gen_cols();
        cols_t            c;
        logic [SynBits:0] r;
        r = {{SynBits{1'b0}}, 1'b1};
        for (int i = 0; i < CodeBits; i++)
        begin
            c[i] = r[SynBits-1:0];
            r = r << 1;
            if (r[SynBits])
            begin
                r = r ^ GenPoly;
            end
        end
        return c;
    endfunction

    localparam cols_t Cols = gen_cols();

    // For each syndrome bit, the set of code positions that contribute to it.
    function automatic masks_t gen_masks();
        masks_t m;
        for (int b = 0; b < SynBits; b++)
        begin
            for (int i = 0; i < CodeBits; i++)
            begin
                m[b][i] = Cols[i][b];
            end
        end
        return m;
    endfunction

    localparam masks_t SynMasks = gen_masks();

endpackage

// ===== rtl/core/bch_31_21_parity_corrector_top.sv =====
// BCH(31,21) two-error corrector with an even parity bit, for pager codewords.
// Input: a transaction is accepted at a rising edge where start is high and
// busy is low. busy is held low, so a new codeword may be offered every cycle.
// Output: each result appears on codeword_out, bits_corrected and uncorrectable
// for exactly one cycle, marked by done; the receiver cannot stall it.
// A codeword accepted at an edge is registered in the syndrome, match and
// correction stages in turn, and its result is presented from the last one.
// Throughput is one codeword per cycle, set by the three register stages:
// syndrome, error-pattern match against all one- and two-bit error syndromes,
// then correction with the overall parity check.
// An unknown syndrome leaves the word unchanged and raises uncorrectable; a
// second BCH correction plus a parity fix also raises uncorrectable, with all
// three flips applied. bits_corrected reads zero whenever uncorrectable is set.
// Reset clears the stage valid bits, so no result is produced for transactions
// in flight when reset is asserted.
`include "bch_31_21_parity_corrector_top_macros.svh"

module bch_31_21_parity_corrector_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  bch_pkg::word_t      codeword_in,
    output logic                done,
    output bch_pkg::word_t      codeword_out,
    output logic [1:0]          bits_corrected,
    output logic                uncorrectable
);
    import bch_pkg::*;

    logic  s1_valid_reg;
    word_t s1_word_reg;
    syn_t  s1_syn_reg;
    syn_t  s1_syn_next;

    logic  s2_valid_reg;
    word_t s2_word_reg;
    flip_t s2_flip_reg;
    logic  s2_unknown_reg;
    logic  s2_single_reg;
    logic  s2_pair_reg;
    flip_t s2_flip_next;
    logic  s2_unknown_next;
    logic  s2_single_next;
    logic  s2_pair_next;

    logic       s3_valid_reg;
    word_t      s3_word_reg;
    logic [1:0] s3_count_reg;
    logic       s3_bad_reg;
    word_t      s3_word_next;
    logic [1:0] s3_count_next;
    logic       s3_bad_next;

    assign busy = 1'b0;

    always_comb
    begin
        for (int b = 0; b < SynBits; b++)
        begin
            s1_syn_next[b] = ^(codeword_in[WordBits-1:1] & SynMasks[b]);
        end
    end

    always_comb
    begin
        logic hit;
        s2_flip_next   = '0;
        s2_single_next = 1'b0;
        s2_pair_next   = 1'b0;
        for (int i = 0; i < CodeBits; i++)
        begin
            hit = (s1_syn_reg == Cols[i]);
            s2_flip_next[i] = s2_flip_next[i] | hit;
            s2_single_next  = s2_single_next | hit;
        end
        for (int i = 0; i < CodeBits; i++)
        begin
            for (int j = i + 1; j < CodeBits; j++)
            begin
                hit = (s1_syn_reg == (Cols[i] ^ Cols[j]));
                s2_flip_next[i] = s2_flip_next[i] | hit;
                s2_flip_next[j] = s2_flip_next[j] | hit;
                s2_pair_next    = s2_pair_next | hit;
            end
        end
        s2_unknown_next = (s1_syn_reg != '0) && !s2_single_next && !s2_pair_next;
    end

    always_comb
    begin
        word_t      fixed;
        logic       par;
        logic [1:0] base;
        fixed = s2_word_reg ^ {s2_flip_reg, 1'b0};
        par   = ^fixed;
        base  = s2_pair_reg ? 2'd2 : (s2_single_reg ? 2'd1 : 2'd0);
        if (s2_unknown_reg)
        begin
            s3_word_next  = s2_word_reg;
            s3_count_next = 2'd0;
            s3_bad_next   = 1'b1;
        end
        else
        begin
            s3_word_next  = {fixed[WordBits-1:1], fixed[0] ^ par};
            s3_bad_next   = par & s2_pair_reg;
            s3_count_next = s3_bad_next ? 2'd0 : (base + {1'b0, par});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_word_reg    <= codeword_in;
        s1_syn_reg     <= s1_syn_next;
        s2_word_reg    <= s1_word_reg;
        s2_flip_reg    <= s2_flip_next;
        s2_unknown_reg <= s2_unknown_next;
        s2_single_reg  <= s2_single_next;
        s2_pair_reg    <= s2_pair_next;
        s3_word_reg    <= s3_word_next;
        s3_count_reg   <= s3_count_next;
        s3_bad_reg     <= s3_bad_next;
    end

    assign done           = s3_valid_reg;
    assign codeword_out   = s3_word_reg;
    assign bits_corrected = s3_count_reg;
    assign uncorrectable  = s3_bad_reg;

    `BCH_ASSERT_DELAY3(a_latency, start && !busy, done)
    `BCH_ASSERT_NEXT(a_zero_syn_known, s1_valid_reg && (s1_syn_reg == '0), !s2_unknown_reg)
    `BCH_ASSERT(a_flip_weight, !s2_valid_reg || ($countones(s2_flip_reg) <= 2))
    `BCH_ASSERT(a_even_parity, !(done && !uncorrectable) || ((^codeword_out) == 1'b0))
    `BCH_ASSERT(a_bad_no_count, !(done && uncorrectable) || (bits_corrected == 2'd0))

endmodule
